FILE: design/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RLPS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define RLPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define RLPS_ASSERT(lbl, clk, rst_n, prop, msg)
`define RLPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: design/rlps_pkg.sv
package rlps_pkg;

    localparam int PIXEL_BITS_DEFAULT  = 24;
    localparam int COLOR_BITS          = 24;
    localparam int SEG_W               = 8;
    localparam int UNIT_W              = 10;
    localparam logic [SEG_W-1:0] SEGMENT_UNITS_RESET = 8'd8;

    typedef enum logic {
        CMD_TICK = 1'b0,
        CMD_LOAD = 1'b1
    } t_command;

    typedef struct packed {
        t_command   command;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_item;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic load_rejected;
        logic frame_done;
    } t_result;

endpackage

FILE: design/rlps_in_stage.sv
module rlps_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  rlps_pkg::t_item i_item,
    output logic            o_valid,
    input  logic            i_take,
    output rlps_pkg::t_item o_item
);

    logic            r_valid;
    rlps_pkg::t_item r_item;

    // a held item leaves in the same cycle a new one comes in
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: design/rlps_encoder.sv
module rlps_encoder #(
    parameter int PIXEL_BITS = rlps_pkg::PIXEL_BITS_DEFAULT
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  rlps_pkg::t_item              i_item,
    input  logic [rlps_pkg::SEG_W-1:0]   i_segment_units,
    output rlps_pkg::t_result            o_result
);

    localparam int BIT_W = $clog2(PIXEL_BITS);
    localparam int SEG_W = rlps_pkg::SEG_W;
    localparam int UNIT_W = rlps_pkg::UNIT_W;
    localparam int CW = rlps_pkg::COLOR_BITS;

    logic [PIXEL_BITS-1:0] r_shift, n_shift;
    logic [BIT_W-1:0]      r_bit_index, n_bit_index;
    logic [UNIT_W-1:0]     r_unit_count, n_unit_count;
    logic                  r_sending, n_sending;

    logic [SEG_W-1:0]         w_seg;
    logic [UNIT_W-1:0]        w_bit_len;
    logic [UNIT_W-1:0]        w_high_len;
    logic [UNIT_W-1:0]        w_unit_inc;
    logic                     w_bit_end;
    logic                     w_last_bit;
    logic [PIXEL_BITS+CW-1:0] w_color_ext;

    assign w_seg      = (i_segment_units == '0) ? SEG_W'(1) : i_segment_units;
    assign w_bit_len  = {w_seg, 2'b00};
    assign w_high_len = r_shift[PIXEL_BITS-1] ? {1'b0, w_seg, 1'b0} : {2'b00, w_seg};
    assign w_unit_inc = r_unit_count + UNIT_W'(1);
    assign w_bit_end  = (w_unit_inc >= w_bit_len);
    assign w_last_bit = (r_bit_index == BIT_W'(PIXEL_BITS - 1));
    // green, red, blue; fit into the pixel word from the low end
    assign w_color_ext = {{PIXEL_BITS{1'b0}}, i_item.green, i_item.red, i_item.blue};

    always_comb begin
        n_shift      = r_shift;
        n_bit_index  = r_bit_index;
        n_unit_count = r_unit_count;
        n_sending    = r_sending;
        o_result     = '0;
        case (i_item.command)
            rlps_pkg::CMD_LOAD: begin
                o_result.busy_res      = 1'b1;
                o_result.load_rejected = r_sending;
                if (!r_sending) begin
                    n_shift      = w_color_ext[PIXEL_BITS-1:0];
                    n_bit_index  = '0;
                    n_unit_count = '0;
                    n_sending    = 1'b1;
                end
            end
            default: begin
                if (r_sending) begin
                    o_result.busy_res   = 1'b1;
                    o_result.line_level = (r_unit_count < w_high_len);
                    n_unit_count        = w_unit_inc;
                    if (w_bit_end) begin
                        n_unit_count = '0;
                        n_shift      = {r_shift[PIXEL_BITS-2:0], 1'b0};
                        n_bit_index  = r_bit_index + BIT_W'(1);
                        if (w_last_bit) begin
                            n_bit_index         = '0;
                            n_sending           = 1'b0;
                            o_result.frame_done = 1'b1;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_index  <= '0;
            r_unit_count <= '0;
            r_sending    <= 1'b0;
        end else if (i_fire) begin
            r_bit_index  <= n_bit_index;
            r_unit_count <= n_unit_count;
            r_sending    <= n_sending;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_shift <= n_shift;
        end
    end

endmodule

FILE: design/rgb_led_pulse_serializer_core.sv
// Pulse-width serializer for a single-wire RGB LED.
//
// Input channel (i_in_valid / o_in_ready): one item per transfer. A tick
// (i_command = 0) is one time unit of the LED waveform; a load (i_command = 1)
// latches green, red, blue and starts a PIXEL_BITS-bit frame, MSB first. A
// load seen while a frame is running is dropped and flagged in o_load_rejected.
// Output channel (o_out_valid / i_out_ready): exactly one result per item:
// line level for that unit, busy, rejected and frame-done flags.
// Each bit is four segments of i_cfg_wdata time units (0 acts as 1); a one is
// two segments high, a zero one segment high. Write the register only idle.
//
// Throughput: one item per cycle while the receiver does not stall; an item
// passes through the input register, then the result register, and the encoder
// state update is add/compare logic between the two registers.
// A stalled receiver holds the result; one more item waits in the input
// register, after which o_in_ready drops until the output drains.
// Reset: idle, segment length 8, both stages empty; the result is not reset.
`include "assert_macros.svh"

module rgb_led_pulse_serializer_core #(
    parameter int PIXEL_BITS = rlps_pkg::PIXEL_BITS_DEFAULT
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rlps_pkg::SEG_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_command,
    input  logic [7:0]                 i_red,
    input  logic [7:0]                 i_green,
    input  logic [7:0]                 i_blue,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_line_level,
    output logic                       o_busy_res,
    output logic                       o_load_rejected,
    output logic                       o_frame_done
);

    logic [rlps_pkg::SEG_W-1:0] r_segment_units;
    logic                       r_out_valid;
    rlps_pkg::t_result          r_result;

    rlps_pkg::t_item   w_in_item;
    rlps_pkg::t_item   w_held_item;
    rlps_pkg::t_result w_result;
    logic              w_held_valid;
    logic              w_fire;

    assign w_in_item.command = rlps_pkg::t_command'(i_command);
    assign w_in_item.red     = i_red;
    assign w_in_item.green   = i_green;
    assign w_in_item.blue    = i_blue;

    assign w_fire = w_held_valid && (!r_out_valid || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_segment_units <= rlps_pkg::SEGMENT_UNITS_RESET;
        end else if (i_cfg_we) begin
            r_segment_units <= i_cfg_wdata;
        end
    end

    rlps_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (w_in_item),
        .o_valid (w_held_valid),
        .i_take  (w_fire),
        .o_item  (w_held_item)
    );

    rlps_encoder #(
        .PIXEL_BITS (PIXEL_BITS)
    ) u_encoder (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_fire          (w_fire),
        .i_item          (w_held_item),
        .i_segment_units (r_segment_units),
        .o_result        (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_result <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_line_level    = r_result.line_level;
    assign o_busy_res      = r_result.busy_res;
    assign o_load_rejected = r_result.load_rejected;
    assign o_frame_done    = r_result.frame_done;

    `RLPS_ASSERT_NEXT(a_fire_gives_result, i_clk, i_rst_n, w_fire, o_out_valid,
        "item moved but no result")
    `RLPS_ASSERT(a_no_accept_when_full, i_clk, i_rst_n,
        (w_held_valid && r_out_valid && !i_out_ready) |-> !o_in_ready,
        "accepted while both stages full")
    `RLPS_ASSERT(a_done_ends_low, i_clk, i_rst_n,
        (o_out_valid && o_frame_done) |-> (o_busy_res && !o_line_level && !o_load_rejected),
        "frame end not in low phase")
    `RLPS_ASSERT(a_reject_is_busy, i_clk, i_rst_n,
        (o_out_valid && o_load_rejected) |-> (o_busy_res && !o_line_level),
        "rejected load not reported busy")

endmodule

FILE: sim/rgb_led_pulse_serializer_core_tb.sv
module rgb_led_pulse_serializer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam realtime CLK_PERIOD  = 8ns;
    localparam int      PIX_BITS    = rlps_pkg::PIXEL_BITS_DEFAULT;
    localparam int      MAX_REPORTS = 50;

    // field order: line_level, busy_res, load_rejected, frame_done
    localparam rlps_pkg::t_result RES_IDLE   = 4'b0000;
    localparam rlps_pkg::t_result RES_ACCEPT = 4'b0100;
    localparam rlps_pkg::t_result RES_REJECT = 4'b0110;

    typedef struct {
        rlps_pkg::t_item   item;
        int                reps;
        bit                has_res;
        rlps_pkg::t_result res;
    } t_dir_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_cfg_we;
    logic [rlps_pkg::SEG_W-1:0]    i_cfg_wdata;
    logic                          i_in_valid;
    logic                          o_in_ready;
    logic                          i_command;
    logic [7:0]                    i_red;
    logic [7:0]                    i_green;
    logic [7:0]                    i_blue;
    logic                          o_out_valid;
    logic                          i_out_ready;
    logic                          o_line_level;
    logic                          o_busy_res;
    logic                          o_load_rejected;
    logic                          o_frame_done;

    // encoder model state
    logic [rlps_pkg::SEG_W-1:0]    led_seg_units = rlps_pkg::SEGMENT_UNITS_RESET;
    logic [PIX_BITS-1:0]           led_pixel     = '0;
    int                            led_bits_sent = 0;
    logic [rlps_pkg::UNIT_W-1:0]   led_unit_cnt  = '0;
    bit                            led_sending   = 1'b0;

    rlps_pkg::t_result             led_expect_q[$];
    t_dir_row                      dir_rows[$];
    int                            err_count = 0;
    bit                            idle_on = 1'b1;
    int                            stall_left = 0;
    rlps_pkg::t_result             mon_act;
    rlps_pkg::t_result             mon_exp;
    string                         res_field_name [4] =
        '{"frame_done", "load_rejected", "busy_res", "line_level"};

    rgb_led_pulse_serializer_core #(
        .PIXEL_BITS(PIX_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_command       (i_command),
        .i_red           (i_red),
        .i_green         (i_green),
        .i_blue          (i_blue),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_line_level    (o_line_level),
        .o_busy_res      (o_busy_res),
        .o_load_rejected (o_load_rejected),
        .o_frame_done    (o_frame_done)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic rlps_pkg::t_result predict_led(input rlps_pkg::t_item it);
        rlps_pkg::t_result res;
        int                seg_len;
        int                high_len;
        res = RES_IDLE;
        seg_len = (led_seg_units == '0) ? 1 : int'(led_seg_units);
        if (it.command == rlps_pkg::CMD_LOAD) begin
            res.busy_res = 1'b1;
            if (led_sending) begin
                res.load_rejected = 1'b1;
            end else begin
                led_pixel     = {it.green, it.red, it.blue};
                led_bits_sent = 0;
                led_unit_cnt  = '0;
                led_sending   = 1'b1;
            end
        end else if (led_sending) begin
            high_len = led_pixel[PIX_BITS-1] ? 2 * seg_len : seg_len;
            res.busy_res   = 1'b1;
            res.line_level = (int'(led_unit_cnt) < high_len);
            led_unit_cnt   = led_unit_cnt + 1'b1;
            if (int'(led_unit_cnt) >= 4 * seg_len) begin
                led_unit_cnt  = '0;
                led_pixel     = led_pixel << 1;
                led_bits_sent = led_bits_sent + 1;
                if (led_bits_sent >= PIX_BITS) begin
                    led_bits_sent  = 0;
                    led_sending    = 1'b0;
                    res.frame_done = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic void add_row(input rlps_pkg::t_command cmd,
                                    input logic [7:0] r, g, b, input int reps,
                                    input bit has_res, input rlps_pkg::t_result res);
        t_dir_row row;
        row.item.command = cmd;
        row.item.red     = r;
        row.item.green   = g;
        row.item.blue    = b;
        row.reps         = reps;
        row.has_res      = has_res;
        row.res          = res;
        dir_rows.push_back(row);
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic rlps_pkg::t_item rand_item(input rlps_pkg::t_command cmd);
        rlps_pkg::t_item it;
        it.command = cmd;
        it.red     = pick_byte();
        it.green   = pick_byte();
        it.blue    = pick_byte();
        return it;
    endfunction

    task automatic send_item(input rlps_pkg::t_item it, input bit has_res,
                             input rlps_pkg::t_result res);
        rlps_pkg::t_result pred;
        int                gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 4);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command  <= it.command;
        i_red      <= it.red;
        i_green    <= it.green;
        i_blue     <= it.blue;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pred = predict_led(it);
        led_expect_q.push_back(has_res ? res : pred);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (led_expect_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_segment(input logic [rlps_pkg::SEG_W-1:0] units);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= units;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        led_seg_units = units;
    endtask

    // ticks until the running frame ends, with the odd load thrown in
    task automatic finish_frame();
        while (led_sending)
            send_item(rand_item($urandom_range(0, 15) == 0 ? rlps_pkg::CMD_LOAD
                                                           : rlps_pkg::CMD_TICK),
                      1'b0, RES_IDLE);
    endtask

    // up to two idle ticks, one load, then ticks until the frame ends
    task automatic run_frame();
        int n;
        n = $urandom_range(0, 2);
        repeat (n) send_item(rand_item(rlps_pkg::CMD_TICK), 1'b0, RES_IDLE);
        send_item(rand_item(rlps_pkg::CMD_LOAD), 1'b0, RES_IDLE);
        finish_frame();
    endtask

    // receiver side: random stall bursts while idle_on is set
    initial begin
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (idle_on && stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 4);
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            mon_act = {o_line_level, o_busy_res, o_load_rejected, o_frame_done};
            if (led_expect_q.size() == 0) begin
                if (err_count < MAX_REPORTS)
                    $display("%0t: result %b with none expected", $time, mon_act);
                err_count++;
            end else begin
                mon_exp = led_expect_q.pop_front();
                for (int f = 0; f < 4; f++) begin
                    if (mon_exp[f] !== mon_act[f]) begin
                        if (err_count < MAX_REPORTS)
                            $display("%0t: %s expected %b actual %b", $time,
                                     res_field_name[f], mon_exp[f], mon_act[f]);
                        err_count++;
                    end
                end
            end
        end
    end

    initial begin
        #(400_000 * CLK_PERIOD);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        i_in_valid  <= 1'b0;
        i_command   <= rlps_pkg::CMD_TICK;
        i_red       <= '0;
        i_green     <= '0;
        i_blue      <= '0;

        // directed rows run at the reset segment length (8 units)
        add_row(rlps_pkg::CMD_TICK, 8'h00, 8'h00, 8'h00, 1,  1'b1, RES_IDLE);
        add_row(rlps_pkg::CMD_TICK, 8'hFF, 8'hFF, 8'hFF, 1,  1'b1, RES_IDLE);
        add_row(rlps_pkg::CMD_LOAD, 8'h00, 8'hFF, 8'h5A, 1,  1'b1, RES_ACCEPT);
        add_row(rlps_pkg::CMD_LOAD, 8'hFF, 8'hFF, 8'hFF, 1,  1'b1, RES_REJECT);
        add_row(rlps_pkg::CMD_TICK, 8'hA5, 8'h5A, 8'hC3, 40, 1'b0, RES_IDLE);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k])
            repeat (dir_rows[k].reps)
                send_item(dir_rows[k].item, dir_rows[k].has_res, dir_rows[k].res);

        // shorter segment mid-frame: the current bit is already past its end
        write_segment(8'd1);
        finish_frame();
        write_segment(8'd0);    // zero acts as one unit
        run_frame();
        write_segment(8'd1);
        run_frame();

        // full rate on both sides
        idle_on = 1'b0;
        run_frame();
        drain();

        if (err_count == 0 && led_expect_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
